[hw/rtl/rpa_pkg.sv]
// Shared widths, register indexes and lookup functions for the airtime block.
// No dependencies; used by radio_packet_airtime and rpa_checker.
package rpa_pkg;

   localparam int LEN_W  = 8;
   localparam int OUT_W  = 26;
   localparam int NUM_W  = 12;
   localparam int DEN1_W = 6;
   localparam int BLK_W  = 7;
   localparam int NSYM_W = 11;
   localparam int QTR_W  = 19;
   localparam int PROD_W = 27;
   localparam int DIV_W  = 39;
   localparam int BW_W   = 19;
   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_SF  = 3'd0;
   localparam logic [2:0] REG_BW  = 3'd1;
   localparam logic [2:0] REG_CR  = 3'd2;
   localparam logic [2:0] REG_PRE = 3'd3;
   localparam logic [2:0] REG_CRC = 3'd4;

   function automatic logic [3:0] clamp_sf(input logic [3:0] sf);
      logic [3:0] r;
      r = sf;
      if (sf < 4'd6) r = 4'd6;
      if (sf > 4'd12) r = 4'd12;
      return r;
   endfunction

   function automatic logic [2:0] clamp_cr(input logic [2:0] cr);
      logic [2:0] r;
      r = cr;
      if (cr < 3'd1) r = 3'd1;
      if (cr > 3'd4) r = 3'd4;
      return r;
   endfunction

   function automatic logic [BW_W-1:0] bw_hz(input logic [3:0] code);
      logic [BW_W-1:0] r;
      case (code)
         4'd0: r = 19'd7800;
         4'd1: r = 19'd10400;
         4'd2: r = 19'd15600;
         4'd3: r = 19'd20800;
         4'd4: r = 19'd31250;
         4'd5: r = 19'd41700;
         4'd6: r = 19'd62500;
         4'd7: r = 19'd125000;
         4'd8: r = 19'd250000;
         default: r = 19'd500000;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/radio_packet_airtime.sv]
// Pipeline: 1 setup stage, 7 block-count cells, 2 symbol/scale stages and
// 26 airtime-division cells. Throughput: one beat per cycle unless the result stalls;
// every cell of both division chains advances together.
// Reset: synchronous, clears all valid flags and loads the register defaults.
// Uses rpa_pkg and rpa_div_cell.
module radio_packet_airtime #(
   parameter int MAX_PAYLOAD = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rpa_pkg::LEN_W-1:0]  req_packet_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rpa_pkg::OUT_W-1:0]  rsp_airtime_ms,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rpa_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import rpa_pkg::*;

   logic [3:0]  sf_ff;
   logic [3:0]  bw_ff;
   logic [2:0]  cr_ff;
   logic [15:0] pre_ff;
   logic        crc_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff  <= 4'd7;
         bw_ff  <= 4'd7;
         cr_ff  <= 3'd1;
         pre_ff <= 16'd8;
         crc_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SF:  sf_ff  <= csr_pwdata[3:0];
            REG_BW:  bw_ff  <= csr_pwdata[3:0];
            REG_CR:  cr_ff  <= csr_pwdata[2:0];
            REG_PRE: pre_ff <= csr_pwdata[15:0];
            REG_CRC: crc_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SF:  csr_prdata = {28'd0, sf_ff};
         REG_BW:  csr_prdata = {28'd0, bw_ff};
         REG_CR:  csr_prdata = {29'd0, cr_ff};
         REG_PRE: csr_prdata = {16'd0, pre_ff};
         REG_CRC: csr_prdata = {31'd0, crc_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   logic [3:0]       sf_c;
   logic [2:0]       cr_c;
   logic [BW_W-1:0]  bw_c;
   logic             en;

   assign sf_c      = clamp_sf(sf_ff);
   assign cr_c      = clamp_cr(cr_ff);
   assign bw_c      = bw_hz(bw_ff);
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // setup stage: ceiling numerator
   logic [LEN_W-1:0]  len_sat;
   logic [NUM_W-1:0]  pos, neg;
   logic              s0_valid_ff;
   logic [NUM_W-1:0]  s0_num_ff, s0_num_in;

   assign len_sat   = (req_packet_length > LEN_W'(MAX_PAYLOAD)) ?
                      LEN_W'(MAX_PAYLOAD) : req_packet_length;
   assign pos       = {1'b0, len_sat, 3'b000} + NUM_W'(28) + {7'd0, crc_ff, 4'b0000};
   assign neg       = {6'd0, sf_c, 2'b00};
   assign s0_num_in = (pos > neg) ? pos - NUM_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) s0_num_ff <= s0_num_in;
   end

   // block-count chain
   logic [DEN1_W-1:0] den1;
   logic              c1_v [0:BLK_W];
   logic [NUM_W-1:0]  c1_r [0:BLK_W];
   logic [BLK_W-1:0]  c1_q [0:BLK_W];

   assign den1    = {sf_c, 2'b00};
   assign c1_v[0] = s0_valid_ff;
   assign c1_r[0] = s0_num_ff;
   assign c1_q[0] = '0;

   for (genvar k = 0; k < BLK_W; k++) begin : g_blk
      rpa_div_cell #(.RW(NUM_W), .DW(DEN1_W), .QB(BLK_W), .SHIFT(BLK_W-1-k)) u_cell (
         .clock, .reset, .en, .den(den1),
         .prev_valid(c1_v[k]), .prev_rem(c1_r[k]), .prev_quo(c1_q[k]),
         .next_valid(c1_v[k+1]), .next_rem(c1_r[k+1]), .next_quo(c1_q[k+1])
      );
   end

   // quarter-symbol count, then scale
   logic [NSYM_W-1:0] nsym;
   logic              sq_valid_ff;
   logic [QTR_W-1:0]  sq_ff, sq_in;
   logic              sd_valid_ff;
   logic [DIV_W-1:0]  sd_ff, sd_in;
   logic [PROD_W-1:0] prod;

   assign nsym  = NSYM_W'(c1_q[BLK_W]) * NSYM_W'({1'b0, cr_c} + 4'd4) + NSYM_W'(8);
   assign sq_in = {1'b0, pre_ff, 2'b00} + QTR_W'(17) + QTR_W'({nsym, 2'b00});
   assign prod  = PROD_W'(sq_ff) * PROD_W'(250);
   assign sd_in = DIV_W'(prod) << sf_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sd_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= c1_v[BLK_W];
         sd_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
         sd_ff <= sd_in;
      end
   end

   // airtime division chain
   logic              c2_v [0:OUT_W];
   logic [DIV_W-1:0]  c2_r [0:OUT_W];
   logic [OUT_W-1:0]  c2_q [0:OUT_W];

   assign c2_v[0] = sd_valid_ff;
   assign c2_r[0] = sd_ff;
   assign c2_q[0] = '0;

   for (genvar k = 0; k < OUT_W; k++) begin : g_ms
      rpa_div_cell #(.RW(DIV_W), .DW(BW_W), .QB(OUT_W), .SHIFT(OUT_W-1-k)) u_cell (
         .clock, .reset, .en, .den(bw_c),
         .prev_valid(c2_v[k]), .prev_rem(c2_r[k]), .prev_quo(c2_q[k]),
         .next_valid(c2_v[k+1]), .next_rem(c2_r[k+1]), .next_quo(c2_q[k+1])
      );
   end

   assign rsp_valid      = c2_v[OUT_W];
   assign rsp_airtime_ms = c2_q[OUT_W];

endmodule

[hw/rtl/rpa_div_cell.sv]
// One restoring-division cell: settles one quotient bit and passes the beat on.
// Depends on nothing; chained by radio_packet_airtime.
module rpa_div_cell #(
   parameter int RW    = 12,
   parameter int DW    = 6,
   parameter int QB    = 7,
   parameter int SHIFT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [DW-1:0] den,
   input  logic          prev_valid,
   input  logic [RW-1:0] prev_rem,
   input  logic [QB-1:0] prev_quo,
   output logic          next_valid,
   output logic [RW-1:0] next_rem,
   output logic [QB-1:0] next_quo
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [RW-1:0] den_ext;
   logic          take;

   assign den_ext = RW'(den);
   assign take    = (prev_rem >> SHIFT) >= den_ext;
   assign rem_in  = take ? prev_rem - (den_ext << SHIFT) : prev_rem;
   assign quo_in  = (prev_quo << 1) | QB'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_rem   = rem_ff;
   assign next_quo   = quo_ff;

endmodule

[hw/rtl/rpa_checker.sv]
// Port-level checks for radio_packet_airtime, bound to the top level.
// Uses rpa_pkg for port widths.
module rpa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [rpa_pkg::OUT_W-1:0]  rsp_airtime_ms,
   input logic                       csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_stall_path: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output back-pressure");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_airtime_ms))
      else $error("stalled result beat changed");

   a_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind radio_packet_airtime rpa_checker u_rpa_checker (.*);
